### rtl/mark_bitmap_range_engine_assert.svh
// ----------------------------------------------------------------------------
// Mark bitmap range engine: assertion macros
// Property wrappers for the checker file.
// ----------------------------------------------------------------------------
`ifndef MARK_BITMAP_RANGE_ENGINE_ASSERT_SVH
`define MARK_BITMAP_RANGE_ENGINE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MBRE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define MBRE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mbre_pkg.sv
// ----------------------------------------------------------------------------
// Mark bitmap range engine package
// Types, codes and defaults shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbre_pkg;

  localparam int DEF_REGION_BITS = 65536;
  localparam int DEF_WORD_BITS   = 32;

  localparam logic [16:0] REGION_RESET = 17'd65536;

  typedef enum logic [1:0] {
    ACT_SET       = 2'd0,
    ACT_CLEAR     = 2'd1,
    ACT_CLEAR_ALL = 2'd2,
    ACT_MARK_ALL  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SEEK,
    ST_RD,
    ST_WR,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic seek;
    logic rd;
    logic wr;
    logic sweep;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    action_t act;
    logic    range_ok;
    logic    q_ok;
    logic    last_word;
    logic    past_hi;
  } dp_status_t;

endpackage

### rtl/mark_bitmap_range_engine.sv
// ----------------------------------------------------------------------------
// Mark bitmap range engine
// One mark bit per byte of a string region, with range set, range clear,
// clear-all and mark-all requests.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// request   start, busy            action, start_offset, span_length
// result    done (one cycle)       any_new
// config    cfg_write              cfg_data (region_bytes)
//
// Set or clear over k words: a seek state, then a read state and a write state
// per word for the read-modify-write on the single memory port.
// Clear all and mark all: one word write for each of the REGION_BITS / WORD_BITS words.
// After reset a clearing pass over all REGION_BITS / WORD_BITS words holds busy high.
// A request is taken when start is high and busy is low; results cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mark_bitmap_range_engine #(
  parameter int REGION_BITS = mbre_pkg::DEF_REGION_BITS,
  parameter int WORD_BITS   = mbre_pkg::DEF_WORD_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [15:0] start_offset,
  input  logic [16:0] span_length,
  output logic        done,
  output logic        any_new,
  input  logic        cfg_write,
  input  logic [16:0] cfg_data
);
  import mbre_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mbre_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  mbre_dpath #(
    .REGION_BITS (REGION_BITS),
    .WORD_BITS   (WORD_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .action       (action),
    .start_offset (start_offset),
    .span_length  (span_length),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .any_new      (any_new)
  );

endmodule

### rtl/mbre_ctrl.sv
// ----------------------------------------------------------------------------
// Mark bitmap range engine: controller
// Sequences reset clearing, range read-modify-write and whole-bitmap sweeps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbre_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  mbre_pkg::dp_status_t   status,
  output mbre_pkg::ctrl_cmd_t    cmd,
  output logic                   busy,
  output logic                   done
);
  import mbre_pkg::*;

  state_t state;
  state_t state_next;
  logic   range_act;

  assign range_act = status.act inside {ACT_SET, ACT_CLEAR};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (status.last_word) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_SEEK;
      end
      ST_SEEK: begin
        if (!range_act) begin
          state_next = ST_SWEEP;
        end else if (status.range_ok && status.q_ok) begin
          state_next = ST_RD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_RD: begin
        state_next = ST_WR;
      end
      ST_WR: begin
        if (status.last_word || status.past_hi) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_SWEEP: begin
        if (status.last_word) state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.sweep = 1'b1;
        cmd.step  = 1'b1;
      end
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SEEK: begin
        cmd.seek = range_act;
      end
      ST_RD: begin
        cmd.rd = 1'b1;
      end
      ST_WR: begin
        cmd.wr   = 1'b1;
        cmd.step = 1'b1;
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        cmd.step  = 1'b1;
      end
      ST_DONE: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

### rtl/mbre_dpath.sv
// ----------------------------------------------------------------------------
// Mark bitmap range engine: datapath
// Holds the bitmap memory, range bounds, word pointer and mask generation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbre_dpath #(
  parameter int REGION_BITS = mbre_pkg::DEF_REGION_BITS,
  parameter int WORD_BITS   = mbre_pkg::DEF_WORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mbre_pkg::ctrl_cmd_t   cmd,
  output mbre_pkg::dp_status_t  status,
  input  logic [1:0]            action,
  input  logic [15:0]           start_offset,
  input  logic [16:0]           span_length,
  input  logic                  cfg_write,
  input  logic [16:0]           cfg_data,
  output logic                  any_new
);
  import mbre_pkg::*;

  localparam int DEPTH = REGION_BITS / WORD_BITS;
  localparam int DW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = ($clog2(REGION_BITS + 1) > 17) ? $clog2(REGION_BITS + 1) : 17;
  localparam int L     = $clog2(WORD_BITS);
  localparam int SH    = 16 + L;
  localparam int RW    = SH - L + 2;
  localparam int MW    = 16 + RW;
  localparam int BW    = $clog2(WORD_BITS + 1);
  localparam longint unsigned RECIP_FULL = ((longint'(1) << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_FULL);

  logic [WORD_BITS-1:0] mem [DEPTH];

  logic [16:0]          region_bytes;
  action_t              act;
  logic [PW-1:0]        lo;
  logic [PW-1:0]        hi;
  logic [PW-1:0]        base;
  logic [DW-1:0]        w;
  logic                 fresh;
  logic [15:0]          q;
  logic [WORD_BITS-1:0] rdata;

  logic [PW:0]          rb;
  logic [PW:0]          sum;
  logic [PW:0]          reg_ext;
  logic [PW-1:0]        range_hi;
  logic [PW-1:0]        mark_hi;
  logic [MW-1:0]        prod;
  logic [PW-1:0]        a_full;
  logic [PW-1:0]        b_full;
  logic [BW-1:0]        a;
  logic [BW-1:0]        b;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] wdata;
  logic                 is_set;

  assign rb       = (PW + 1)'(REGION_BITS);
  assign sum      = (PW + 1)'(start_offset) + (PW + 1)'(span_length);
  assign reg_ext  = (PW + 1)'(region_bytes);
  assign range_hi = (sum > rb) ? rb[PW-1:0] : sum[PW-1:0];
  assign mark_hi  = (reg_ext > rb) ? rb[PW-1:0] : reg_ext[PW-1:0];
  assign prod     = MW'(start_offset) * MW'(RECIP);
  assign is_set   = (act == ACT_SET);

  always_comb begin
    a_full = (lo > base) ? (lo - base) : '0;
    if (hi <= base) begin
      b_full = '0;
    end else if ((hi - base) >= PW'(WORD_BITS)) begin
      b_full = PW'(WORD_BITS);
    end else begin
      b_full = hi - base;
    end
    a = a_full[BW-1:0];
    b = b_full[BW-1:0];
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (BW'(i) >= a) && (BW'(i) < b);
    end
  end

  always_comb begin
    if (cmd.sweep) begin
      wdata = mask;
    end else if (is_set) begin
      wdata = rdata | mask;
    end else begin
      wdata = rdata & ~mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_bytes <= REGION_RESET;
      act          <= ACT_CLEAR_ALL;
      lo           <= '0;
      hi           <= '0;
      base         <= '0;
      w            <= '0;
      fresh        <= 1'b0;
    end else begin
      if (cfg_write) region_bytes <= cfg_data;
      if (cmd.load) begin
        act   <= action_t'(action);
        fresh <= 1'b0;
        w     <= '0;
        base  <= '0;
        case (action_t'(action))
          ACT_SET, ACT_CLEAR: begin
            lo <= PW'(start_offset);
            hi <= range_hi;
          end
          ACT_MARK_ALL: begin
            lo <= '0;
            hi <= mark_hi;
          end
          default: begin
            lo <= '0;
            hi <= '0;
          end
        endcase
      end else if (cmd.seek) begin
        w    <= DW'(q);
        base <= PW'(PW'(q) * PW'(WORD_BITS));
      end else if (cmd.step) begin
        w    <= w + DW'(1);
        base <= base + PW'(WORD_BITS);
      end
      if (cmd.wr && is_set) fresh <= fresh | (|(~rdata & mask));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) q <= 16'(prod >> SH);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr || cmd.sweep) mem[w] <= wdata;
    if (cmd.rd) rdata <= mem[w];
  end

  always_comb begin
    status.act       = act;
    status.range_ok  = (hi > lo);
    status.q_ok      = ((PW + 1)'(q) < (PW + 1)'(DEPTH));
    status.last_word = (w == DW'(DEPTH - 1));
    status.past_hi   = (((PW + 1)'(base) + (PW + 1)'(WORD_BITS)) >= (PW + 1)'(hi));
  end

  always_comb begin
    case (act)
      ACT_SET:      any_new = fresh;
      ACT_MARK_ALL: any_new = (hi != '0);
      default:      any_new = 1'b0;
    endcase
  end

endmodule

### rtl/mbre_checker.sv
// ----------------------------------------------------------------------------
// Mark bitmap range engine: port checker
// Watches the request and result handshakes over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mark_bitmap_range_engine_assert.svh"

module mbre_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `MBRE_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted beat did not raise busy")
  `MBRE_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result strobe longer than one cycle")
  `MBRE_ASSERT_NEXT(a_done_idle, clk, rst, done, !busy, "engine not idle after result")
  `MBRE_ASSERT_NOW(a_reset_clear, clk, rst, $fell(rst), busy, "no clearing pass after reset")

endmodule

bind mark_bitmap_range_engine mbre_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

### tb/mark_bitmap_range_engine_tb.sv
// ----------------------------------------------------------------------------
// Mark bitmap range engine testbench
// Drives set range, clear range, clear-all and mark-all requests through the
// start/busy command port. A shadow bitmap in the testbench predicts any_new
// for each accepted beat, and every done strobe is checked in order against
// those predictions. The test covers directed word-boundary and clipping
// cases, region_bytes settings from 0 to past the bitmap end, and random
// traffic under three sender idle profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mark_bitmap_range_engine_tb;
  import mbre_pkg::*;

  localparam int          NBITS      = DEF_REGION_BITS;
  localparam int          WBITS      = DEF_WORD_BITS;
  localparam int          NWORDS     = NBITS / WBITS;
  localparam int          QUIET_MAX  = 50000;
  localparam int          DRAIN_WAIT = 8;
  localparam logic [16:0] FULL_SPAN  = 17'd65536;
  localparam logic [16:0] REGION_MAX = 17'h1FFFF;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        start        = 1'b0;
  logic [1:0]  action       = ACT_SET;
  logic [15:0] start_offset = '0;
  logic [16:0] span_length  = '0;
  logic        cfg_write    = 1'b0;
  logic [16:0] cfg_data     = '0;
  logic        busy;
  logic        done;
  logic        any_new;

  logic [WBITS-1:0] mark_shadow [NWORDS];
  logic [16:0]      region_shadow = REGION_RESET;
  logic             any_new_expected [$];
  int               error_count     = 0;
  int               sender_idle_pct = 0;

  mark_bitmap_range_engine i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .start_offset (start_offset),
    .span_length  (span_length),
    .done         (done),
    .any_new      (any_new),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    foreach (mark_shadow[i]) mark_shadow[i] = '0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    error_count++;
  endtask

  function automatic logic mark_span(input int unsigned lo, input int unsigned hi,
                                     input logic set_bits);
    logic             fresh;
    int unsigned      base;
    int unsigned      a;
    int unsigned      b;
    logic [WBITS-1:0] m;
    fresh = 1'b0;
    if (lo >= hi) return 1'b0;
    for (int unsigned w = lo / WBITS; w <= (hi - 1) / WBITS; w++) begin
      base = w * WBITS;
      a    = (lo > base) ? lo - base : 0;
      b    = (hi - base >= WBITS) ? WBITS : hi - base;
      m    = ({WBITS{1'b1}} << a) & ({WBITS{1'b1}} >> (WBITS - b));
      if (set_bits) begin
        if ((~mark_shadow[w] & m) != '0) fresh = 1'b1;
        mark_shadow[w] = mark_shadow[w] | m;
      end else begin
        mark_shadow[w] = mark_shadow[w] & ~m;
      end
    end
    return fresh;
  endfunction

  function automatic logic predict_any_new(input action_t act, input logic [15:0] off,
                                           input logic [16:0] len);
    int unsigned hi;
    logic        fresh;
    case (act)
      ACT_SET, ACT_CLEAR: begin
        if (len == '0) return 1'b0;
        hi = int'(off) + int'(len);
        if (hi > NBITS) hi = NBITS;
        fresh = mark_span(off, hi, act == ACT_SET);
        return (act == ACT_SET) ? fresh : 1'b0;
      end
      default: begin
        foreach (mark_shadow[i]) mark_shadow[i] = '0;
        if (act == ACT_CLEAR_ALL) return 1'b0;
        hi = region_shadow;
        if (hi > NBITS) hi = NBITS;
        return mark_span(0, hi, 1'b1);
      end
    endcase
  endfunction

  // check results and record expectations; check first so a beat accepted
  // on this edge never answers a strobe on the same edge
  always @(posedge clk) begin : result_check
    logic exp_bit;
    if (!rst) begin
      if (done) begin
        if (any_new_expected.size() == 0) begin
          report_mismatch("done strobe with no request pending");
        end else begin
          exp_bit = any_new_expected.pop_front();
          if (any_new !== exp_bit)
            report_mismatch($sformatf("any_new %b, expected %b", any_new, exp_bit));
        end
      end
      if (start && !busy)
        any_new_expected.push_back(predict_any_new(action_t'(action), start_offset,
                                                   span_length));
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (start && !busy) || done) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_MAX) begin
        $display("%0t ns timeout: no beat for %0d cycles", $time, QUIET_MAX);
        $display("mark_bitmap_range_engine_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send_request(input action_t act, input logic [15:0] off,
                              input logic [16:0] len);
    do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    start        <= 1'b1;
    action       <= act;
    start_offset <= off;
    span_length  <= len;
    do @(posedge clk); while (busy);
    start <= 1'b0;
  endtask

  task automatic write_region(input logic [16:0] value);
    do @(negedge clk); while (any_new_expected.size() != 0 || busy);
    @(posedge clk);
    cfg_write     <= 1'b1;
    cfg_data      <= value;
    region_shadow  = value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic test_range_edges();
    send_request(ACT_SET,   16'd0,     17'd1);
    send_request(ACT_SET,   16'd0,     17'd1);
    send_request(ACT_SET,   16'd31,    17'd2);
    send_request(ACT_SET,   16'd0,     17'd0);
    send_request(ACT_CLEAR, 16'd0,     17'd0);
    send_request(ACT_SET,   16'd65535, 17'd1);
    send_request(ACT_SET,   16'd65535, FULL_SPAN);
    send_request(ACT_SET,   16'd100,   FULL_SPAN);
    send_request(ACT_CLEAR, 16'd40000, 17'd33);
    send_request(ACT_SET,   16'd40000, 17'd33);
    send_request(ACT_CLEAR, 16'd0,     FULL_SPAN);
    send_request(ACT_SET,   16'd32,    17'd32);
    send_request(ACT_CLEAR, 16'd33,    17'd30);
    send_request(ACT_SET,   16'd32,    17'd32);
  endtask

  task automatic test_bulk_and_region();
    send_request(ACT_CLEAR_ALL, 16'hFFFF, REGION_MAX);
    send_request(ACT_SET,       16'd32,   17'd32);
    send_request(ACT_MARK_ALL,  16'd0,    17'd0);
    send_request(ACT_SET,       16'd0,    FULL_SPAN);
    write_region(17'd0);
    send_request(ACT_MARK_ALL,  16'd7,    17'd9);
    send_request(ACT_SET,       16'd5,    17'd1);
    write_region(17'd1);
    send_request(ACT_MARK_ALL,  16'd0,    17'd0);
    send_request(ACT_SET,       16'd0,    17'd2);
    write_region(REGION_MAX);
    send_request(ACT_MARK_ALL,  16'd0,    17'd0);
    send_request(ACT_SET,       16'd65535, 17'd1);
    write_region(17'd33);
    send_request(ACT_MARK_ALL,  16'd0,    17'd0);
    send_request(ACT_SET,       16'd32,   17'd2);
    write_region(17'd65535);
    send_request(ACT_MARK_ALL,  16'd0,    17'd0);
    send_request(ACT_SET,       16'd65535, 17'd1);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int count,
                                     input logic [16:0] region);
    action_t     act;
    logic [15:0] off;
    logic [16:0] len;
    logic [15:0] last_off;
    logic [16:0] last_len;
    int          pick;
    last_off = '0;
    last_len = 17'd1;
    sender_idle_pct = idle_pct;
    write_region(region);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 4)       act = ACT_CLEAR_ALL;
      else if (pick < 10) act = ACT_MARK_ALL;
      else if (pick < 60) act = ACT_SET;
      else                act = ACT_CLEAR;
      pick = $urandom_range(99);
      if (pick < 20)      off = last_off;
      else if (pick < 55) off = 16'($urandom_range(1023));
      else if (pick < 65) off = 16'(65535 - $urandom_range(600));
      else                off = 16'($urandom);
      if (pick < 20) begin
        len = last_len;
      end else begin
        pick = $urandom_range(99);
        if (pick < 5)       len = '0;
        else if (pick < 75) len = 17'($urandom_range(96, 1));
        else if (pick < 93) len = 17'($urandom_range(2048, 97));
        else                len = 17'($urandom_range(65536));
      end
      last_off = off;
      last_len = len;
      send_request(act, off, len);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    sender_idle_pct = 21;
    test_range_edges();
    test_bulk_and_region();
    test_random_traffic(21, 130, 17'($urandom_range(131071)));
    test_random_traffic(45, 130, REGION_RESET);
    test_random_traffic(0, 140, 17'($urandom_range(2048)));
    do @(negedge clk); while (any_new_expected.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("mark_bitmap_range_engine_tb OK");
    end else begin
      $display("mark_bitmap_range_engine_tb NOT OK");
    end
    $finish;
  end

endmodule
